FILE: rtl/core/wfgp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfgp_pkg
// Shared widths, operation codes and the command/status bundles that pass
// between the word FIFO controller and its datapath.
// ----------------------------------------------------------------------------
package wfgp_pkg;

  localparam int RING_DEPTH_DEF = 256;

  localparam int WORD_W = 32;
  localparam int OP_W   = 2;
  localparam int GRP_W  = 4;
  localparam int GRP_LSB = 24;
  localparam int FILL_W = 8;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_PURGE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic push;
    logic pop_issue;
    logic pop_finish;
    logic purge_start;
    logic purge_read;
    logic purge_check;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_done;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/wfgp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfgp_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module wfgp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/wfgp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfgp_ctrl
// Controller state machine: decodes the operation and sequences the pop
// read and the purge walk over the queued entries.
// ----------------------------------------------------------------------------
module wfgp_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [wfgp_pkg::OP_W-1:0]    op,
  input  wire wfgp_pkg::status_t            status,
  output wfgp_pkg::cmd_t                    cmd,
  output logic                              busy
);

  import wfgp_pkg::*;

  localparam logic [1:0] S_IDLE      = 2'd0;
  localparam logic [1:0] S_POP       = 2'd1;
  localparam logic [1:0] S_PURGE_RD  = 2'd2;
  localparam logic [1:0] S_PURGE_CHK = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (op)
            OP_PUSH: begin
              cmd.push = 1'b1;
            end
            OP_POP: begin
              cmd.pop_issue = 1'b1;
              if (!status.empty) begin
                state_next = S_POP;
              end
            end
            OP_PURGE: begin
              cmd.purge_start = 1'b1;
              if (!status.empty) begin
                state_next = S_PURGE_RD;
              end
            end
            OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: begin
              cmd = '0;
            end
          endcase
        end
      end
      S_POP: begin
        cmd.pop_finish = 1'b1;
        state_next     = S_IDLE;
      end
      S_PURGE_RD: begin
        cmd.purge_read = 1'b1;
        state_next     = S_PURGE_CHK;
      end
      S_PURGE_CHK: begin
        cmd.purge_check = 1'b1;
        state_next      = status.scan_done ? S_IDLE : S_PURGE_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/wfgp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfgp_datapath
// Ring positions, slot memory and result registers. A purge streams the old
// entries through the read port and rewrites the kept ones at the write side.
// ----------------------------------------------------------------------------
module wfgp_datapath #(
  parameter int DEPTH = wfgp_pkg::RING_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire wfgp_pkg::cmd_t                 cmd,
  input  wire logic [wfgp_pkg::WORD_W-1:0]    word_in,
  input  wire logic [wfgp_pkg::GRP_W-1:0]     purge_group,
  output wfgp_pkg::status_t                   status,
  output logic                                done,
  output logic                                ok,
  output logic      [wfgp_pkg::WORD_W-1:0]    word_out,
  output logic      [wfgp_pkg::FILL_W-1:0]    fill_count
);

  import wfgp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int XW = CW + FILL_W;

  function automatic logic [AW-1:0] inc_pos(input logic [AW-1:0] p);
    inc_pos = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [AW-1:0]     wr_pos;
  logic [AW-1:0]     rd_pos;
  logic [AW-1:0]     scan_pos;
  logic [AW-1:0]     scan_end;
  logic [GRP_W-1:0]  grp;

  logic [AW-1:0]     wr_inc;
  logic              full;
  logic              empty;
  logic              keep;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [CW-1:0]     cnt;
  logic [XW-1:0]     cnt_x;
  logic              done_next;

  assign wr_inc = inc_pos(wr_pos);
  assign full   = (wr_inc == rd_pos);
  assign empty  = (wr_pos == rd_pos);
  assign keep   = (ram_rdata[GRP_LSB +: GRP_W] != grp);

  assign status.empty     = empty;
  assign status.scan_done = (inc_pos(scan_pos) == scan_end);

  assign ram_we    = (cmd.push && !full) || (cmd.purge_check && keep);
  assign ram_wdata = cmd.push ? word_in : ram_rdata;
  assign ram_re    = cmd.pop_issue || cmd.purge_read;
  assign ram_raddr = cmd.pop_issue ? rd_pos : scan_pos;

  // one result beat per finished operation
  assign done_next = cmd.push || (cmd.pop_issue && empty) || cmd.pop_finish ||
                     (cmd.purge_start && empty) ||
                     (cmd.purge_check && status.scan_done) || cmd.clear;

  wfgp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_pos),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // positions and results
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
      rd_pos <= '0;
      done   <= 1'b0;
    end else begin
      done <= done_next;
      if (cmd.push) begin
        if (!full) begin
          wr_pos <= wr_inc;
        end
        ok       <= !full;
        word_out <= '0;
      end
      if (cmd.pop_issue && empty) begin
        ok       <= 1'b0;
        word_out <= '0;
      end
      if (cmd.pop_finish) begin
        rd_pos   <= inc_pos(rd_pos);
        ok       <= 1'b1;
        word_out <= ram_rdata;
      end
      if (cmd.purge_start) begin
        scan_pos <= rd_pos;
        scan_end <= wr_pos;
        rd_pos   <= wr_pos;
        grp      <= purge_group;
        if (empty) begin
          ok       <= 1'b1;
          word_out <= '0;
        end
      end
      if (cmd.purge_check) begin
        if (keep) begin
          wr_pos <= wr_inc;
        end
        scan_pos <= inc_pos(scan_pos);
        if (status.scan_done) begin
          ok       <= 1'b1;
          word_out <= '0;
        end
      end
      if (cmd.clear) begin
        wr_pos   <= '0;
        rd_pos   <= '0;
        ok       <= 1'b1;
        word_out <= '0;
      end
    end
  end

  // queued words, saturated to the field width
  assign cnt = (wr_pos >= rd_pos) ? (CW'(wr_pos) - CW'(rd_pos))
                                  : (CW'(wr_pos) + CW'(DEPTH) - CW'(rd_pos));
  assign cnt_x = XW'(cnt);
  assign fill_count = (cnt_x > XW'(255)) ? '1 : cnt_x[FILL_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/word_fifo_with_group_purge.sv
`default_nettype none
// Push and clear give their result in the cycle after the start beat. A pop reads the RAM
// in the start beat and finishes in S_POP (an empty pop answers like a push); a purge walks
// S_PURGE_RD and S_PURGE_CHK once per queued word, one RAM read per word. A new start is
// taken in the cycle its predecessor's result is shown; results cannot stall.
// Reset clears both ring positions and the controller; slot memory is not cleared.
// ----------------------------------------------------------------------------
// word_fifo_with_group_purge
// Circular FIFO of 32-bit words with push, pop, group purge and clear; one
// slot stays empty, so it holds up to DEPTH - 1 words.
// ----------------------------------------------------------------------------
module word_fifo_with_group_purge #(
  parameter int DEPTH = wfgp_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [wfgp_pkg::OP_W-1:0]     op,
  input  wire logic [wfgp_pkg::WORD_W-1:0]   word_in,
  input  wire logic [wfgp_pkg::GRP_W-1:0]    purge_group,
  output logic                               done,
  output logic                               ok,
  output logic      [wfgp_pkg::WORD_W-1:0]   word_out,
  output logic      [wfgp_pkg::FILL_W-1:0]   fill_count
);

  import wfgp_pkg::*;

  cmd_t    cmd;
  status_t status;

  wfgp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  wfgp_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .word_in     (word_in),
    .purge_group (purge_group),
    .status      (status),
    .done        (done),
    .ok          (ok),
    .word_out    (word_out),
    .fill_count  (fill_count)
  );

`ifndef ASSERT_OFF
  // a result beat always lands with the controller back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while controller busy");

  a_single_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (op == OP_PUSH || op == OP_CLEAR) |=> done)
    else $error("push or clear did not finish in one cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && !ok |-> word_out == '0)
    else $error("failed operation returned a word");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    start && !busy && op == OP_CLEAR |=> fill_count == '0)
    else $error("fill count not zero after clear");
`endif

endmodule

`default_nettype wire

FILE: test/word_fifo_with_group_purge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_fifo_with_group_purge_checker
// Watches the command and result beats of the word FIFO, keeps its own ring
// of queued words and compares every result beat, field by field, with the
// status the ring predicts for the oldest outstanding command.
// ----------------------------------------------------------------------------
module word_fifo_with_group_purge_checker
  import wfgp_pkg::*;
#(
  parameter int DEPTH = RING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [OP_W-1:0]   op,
  input  logic [WORD_W-1:0] word_in,
  input  logic [GRP_W-1:0]  purge_group,
  input  logic              done,
  input  logic              ok,
  input  logic [WORD_W-1:0] word_out,
  input  logic [FILL_W-1:0] fill_count,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] word;
    logic [FILL_W-1:0] fill;
  } fifo_status_t;

  logic [WORD_W-1:0] ring_words [DEPTH];
  int unsigned       wr_ptr;
  int unsigned       rd_ptr;
  fifo_status_t      status_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    wr_ptr     = 0;
    rd_ptr     = 0;
  end

  function automatic fifo_status_t apply_command(logic [OP_W-1:0] cmd,
                                                 logic [WORD_W-1:0] w,
                                                 logic [GRP_W-1:0] grp);
    fifo_status_t      res;
    logic [WORD_W-1:0] kept [$];
    int unsigned       n;
    res    = '0;
    res.ok = 1'b1;
    case (cmd)
      OP_PUSH: begin
        if ((wr_ptr + 1) % DEPTH == rd_ptr) begin
          res.ok = 1'b0;
        end else begin
          ring_words[wr_ptr] = w;
          wr_ptr = (wr_ptr + 1) % DEPTH;
        end
      end
      OP_POP: begin
        if (wr_ptr == rd_ptr) begin
          res.ok = 1'b0;
        end else begin
          res.word = ring_words[rd_ptr];
          rd_ptr = (rd_ptr + 1) % DEPTH;
        end
      end
      OP_PURGE: begin
        while (rd_ptr != wr_ptr) begin
          if (ring_words[rd_ptr][GRP_LSB +: GRP_W] != grp) kept.push_back(ring_words[rd_ptr]);
          rd_ptr = (rd_ptr + 1) % DEPTH;
        end
        // survivors land again from the old write position on
        foreach (kept[i]) begin
          ring_words[wr_ptr] = kept[i];
          wr_ptr = (wr_ptr + 1) % DEPTH;
        end
      end
      OP_CLEAR: begin
        wr_ptr = 0;
        rd_ptr = 0;
      end
      default: begin
      end
    endcase
    n = (wr_ptr + DEPTH - rd_ptr) % DEPTH;
    res.fill = (n > (1 << FILL_W) - 1) ? '1 : n[FILL_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    fifo_status_t want;
    if (rst) begin
      wr_ptr = 0;
      rd_ptr = 0;
      status_q.delete();
    end else begin
      if (done) begin
        if (status_q.size() == 0) begin
          $error("result beat with no command outstanding");
          fail_count++;
        end else begin
          want = status_q.pop_front();
          if (ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, ok);
            fail_count++;
          end
          if (word_out !== want.word) begin
            $error("word_out: expected %08h, got %08h", want.word, word_out);
            fail_count++;
          end
          if (fill_count !== want.fill) begin
            $error("fill_count: expected %0d, got %0d", want.fill, fill_count);
            fail_count++;
          end
        end
      end
      if (start && !busy) status_q.push_back(apply_command(op, word_in, purge_group));
    end
    pending = status_q.size();
  end

endmodule

FILE: test/word_fifo_with_group_purge_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_fifo_with_group_purge_tb
// Drives push, pop, purge and clear commands into the word FIFO: a directed
// opening, a fill to full and a drain to empty, then random command mixes
// with random sender gaps. The checker beside the block predicts and checks.
// ----------------------------------------------------------------------------
module word_fifo_with_group_purge_tb;
  import wfgp_pkg::*;

  localparam int DEPTH       = RING_DEPTH_DEF;
  localparam int STALL_LIMIT = 4000;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              start       = 1'b0;
  logic [OP_W-1:0]   op          = OP_PUSH;
  logic [WORD_W-1:0] word_in     = '0;
  logic [GRP_W-1:0]  purge_group = '0;
  logic              busy;
  logic              done;
  logic              ok;
  logic [WORD_W-1:0] word_out;
  logic [FILL_W-1:0] fill_count;

  int                fail_count;
  int                pending;
  int                stall_cycles = 0;
  bit                idle_en      = 1'b1;
  logic [GRP_W-1:0]  last_grp     = '0;

  always #2 clk = ~clk;

  word_fifo_with_group_purge #(.DEPTH(DEPTH)) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .word_in     (word_in),
    .purge_group (purge_group),
    .done        (done),
    .ok          (ok),
    .word_out    (word_out),
    .fill_count  (fill_count)
  );

  word_fifo_with_group_purge_checker #(.DEPTH(DEPTH)) u_chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .word_in     (word_in),
    .purge_group (purge_group),
    .done        (done),
    .ok          (ok),
    .word_out    (word_out),
    .fill_count  (fill_count),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // watchdog: cycles with neither a command nor a result beat
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_cmd(logic [OP_W-1:0] c, logic [WORD_W-1:0] w, logic [GRP_W-1:0] g);
    bit taken;
    while (idle_en && $urandom_range(0, 99) < 36) begin
      start       <= 1'b0;
      op          <= OP_W'($urandom);
      word_in     <= $urandom;
      purge_group <= GRP_W'($urandom);
      @(negedge clk);
    end
    start       <= 1'b1;
    op          <= c;
    word_in     <= w;
    purge_group <= g;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
  endtask

  task automatic send_random(int push_pct, int pop_pct, int purge_pct);
    int                r;
    logic [WORD_W-1:0] w;
    logic [GRP_W-1:0]  g;
    r = $urandom_range(0, 99);
    w = $urandom;
    g = GRP_W'($urandom);
    // crowd half the words into a few groups so purges find matches
    if ($urandom_range(0, 1)) w[GRP_LSB +: GRP_W] = GRP_W'($urandom_range(0, 3));
    if (r < push_pct) begin
      last_grp = w[GRP_LSB +: GRP_W];
      send_cmd(OP_PUSH, w, g);
    end else if (r < push_pct + pop_pct) begin
      send_cmd(OP_POP, w, g);
    end else if (r < push_pct + pop_pct + purge_pct) begin
      if ($urandom_range(0, 99) < 70) g = last_grp;
      send_cmd(OP_PURGE, w, g);
    end else begin
      send_cmd(OP_CLEAR, w, g);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int push_pct;
    int purge_pct;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty FIFO corner cases
    send_cmd(OP_POP,   32'h0000_0000, 4'h0);
    send_cmd(OP_PURGE, 32'h0000_0000, 4'h0);
    send_cmd(OP_CLEAR, 32'hFFFF_FFFF, 4'hF);
    // field extremes and a spread of groups
    send_cmd(OP_PUSH,  32'h0000_0000, 4'hF);
    send_cmd(OP_PUSH,  32'hFFFF_FFFF, 4'h0);
    send_cmd(OP_PUSH,  32'h0A5A_5A5A, 4'h0);
    send_cmd(OP_PUSH,  32'hF0FF_FFFF, 4'h0);
    send_cmd(OP_PUSH,  32'h0F00_0000, 4'h0);
    // purge takes out two words from the middle and back
    send_cmd(OP_PURGE, 32'h0000_0000, 4'hF);
    send_cmd(OP_POP,   32'h0000_0000, 4'h0);
    send_cmd(OP_POP,   32'h0000_0000, 4'h0);
    send_cmd(OP_PUSH,  32'h1234_5678, 4'h0);
    send_cmd(OP_CLEAR, 32'h0000_0000, 4'h0);
    send_cmd(OP_POP,   32'h0000_0000, 4'h0);
    send_cmd(OP_PUSH,  32'h8000_0001, 4'h0);
    send_cmd(OP_PUSH,  32'h7700_0000, 4'h0);
    // purge with no match keeps everything in order
    send_cmd(OP_PURGE, 32'h0000_0000, 4'h5);
    send_cmd(OP_POP,   32'h0000_0000, 4'h0);
    send_cmd(OP_POP,   32'h0000_0000, 4'h0);
    send_cmd(OP_POP,   32'h0000_0000, 4'h0);
    send_cmd(OP_PURGE, 32'hFFFF_FFFF, 4'hF);

    repeat (250) send_random(45, 35, 15);
    wait_drained();

    // long stretch with no sender gaps: fill past full, churn, drain past empty
    idle_en = 1'b0;
    repeat (280) send_random(100, 0, 0);
    repeat (40) send_random(60, 20, 15);
    repeat (260) send_random(5, 90, 5);
    idle_en = 1'b1;

    repeat (8) begin
      push_pct  = $urandom_range(25, 70);
      purge_pct = $urandom_range(3, 12);
      repeat (100) send_random(push_pct, 97 - push_pct - purge_pct, purge_pct);
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
